// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; every other file refers to it by scoped names.
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 4;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_REM_FRONT = 4'd3,
    OP_REM_BACK  = 4'd4,
    OP_REM_AT    = 4'd5,
    OP_READ      = 4'd6,
    OP_WRITE     = 4'd7,
    OP_CLEAR     = 4'd8
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Broadcast action for the cell row
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

  // Result bookkeeping from the controller
  typedef struct packed {
    logic              take;
    status_t           status;
    logic [CNT_W-1:0]  length;
  } result_t;

endpackage

// ===== rtl/ple_cell.sv =====
// One list slot: holds an entry and trades it with its neighbors.
// Depends on ple_pkg for the command struct and widths.
module ple_cell (
  input  logic                         clk,
  input  logic [ple_pkg::IDX_W-1:0]    slot,
  input  ple_pkg::cell_cmd_t           cmd,
  input  logic [ple_pkg::VAL_W-1:0]    left,
  input  logic [ple_pkg::VAL_W-1:0]    right,
  output logic [ple_pkg::VAL_W-1:0]    q
);

  // Load, shift back, shift forward or hold
  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      ple_pkg::CMD_INSERT: begin
        if (slot == cmd.idx) begin
          q <= cmd.value;
        end else if (slot > cmd.idx) begin
          q <= left;
        end
      end
      ple_pkg::CMD_REMOVE: begin
        if (slot >= cmd.idx) begin
          q <= right;
        end
      end
      ple_pkg::CMD_WRITE: begin
        if (slot == cmd.idx) begin
          q <= cmd.value;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// ===== rtl/ple_ctrl.sv =====
// Operation decoder and length register for the positional list engine.
// Depends on ple_pkg; drives the command broadcast to the cell row.
module ple_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [ple_pkg::OP_W-1:0]     op,
  input  logic [ple_pkg::POS_W-1:0]    pos,
  input  logic [ple_pkg::VAL_W-1:0]    value,
  output ple_pkg::cell_cmd_t           cmd,
  output ple_pkg::result_t             res
);

  logic [ple_pkg::CNT_W-1:0] count;
  logic [ple_pkg::CNT_W-1:0] count_next;
  logic [ple_pkg::CNT_W:0]   count_p1;
  logic [ple_pkg::POS_W-1:0] pos_m1;
  logic [ple_pkg::IDX_W-1:0] pos_idx;
  logic                      full;
  logic                      empty;
  logic                      in_list;
  logic                      ins_ok;

  assign count_p1 = {1'b0, count} + 1'b1;
  assign pos_m1   = pos - 1'b1;
  assign pos_idx  = ple_pkg::IDX_W'(pos_m1);
  assign full     = (count >= ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign in_list  = (pos != '0) && ((ple_pkg::CNT_W+1)'(pos) <= {1'b0, count});
  assign ins_ok   = (pos != '0) && ((ple_pkg::CNT_W+1)'(pos) <= count_p1);

  // Decode one beat into a row command and its result
  always_comb begin
    cmd.kind   = ple_pkg::CMD_NONE;
    cmd.idx    = '0;
    cmd.value  = value;
    res.take   = 1'b0;
    res.status = ple_pkg::ST_OK;
    count_next = count;
    unique case (op) inside
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
        if (full) begin
          res.status = ple_pkg::ST_FULL;
        end else if (op == ple_pkg::OP_INS_AT && !ins_ok) begin
          res.status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.kind   = ple_pkg::CMD_INSERT;
          count_next = ple_pkg::CNT_W'(count_p1);
          if (op == ple_pkg::OP_INS_FRONT) begin
            cmd.idx = '0;
          end else if (op == ple_pkg::OP_INS_BACK) begin
            cmd.idx = ple_pkg::IDX_W'(count);
          end else begin
            cmd.idx = pos_idx;
          end
        end
      end
      ple_pkg::OP_REM_FRONT, ple_pkg::OP_REM_BACK, ple_pkg::OP_REM_AT: begin
        if (empty) begin
          res.status = ple_pkg::ST_EMPTY;
        end else if (op == ple_pkg::OP_REM_AT && !in_list) begin
          res.status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.kind   = ple_pkg::CMD_REMOVE;
          res.take   = 1'b1;
          count_next = count - 1'b1;
          if (op == ple_pkg::OP_REM_FRONT) begin
            cmd.idx = '0;
          end else if (op == ple_pkg::OP_REM_BACK) begin
            cmd.idx = ple_pkg::IDX_W'(count - 1'b1);
          end else begin
            cmd.idx = pos_idx;
          end
        end
      end
      ple_pkg::OP_READ: begin
        cmd.idx = pos_idx;
        if (!in_list) begin
          res.status = ple_pkg::ST_BADPOS;
        end else begin
          res.take = 1'b1;
        end
      end
      ple_pkg::OP_WRITE: begin
        cmd.idx = pos_idx;
        if (!in_list) begin
          res.status = ple_pkg::ST_BADPOS;
        end else begin
          cmd.kind = ple_pkg::CMD_WRITE;
        end
      end
      ple_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    // Drop the row command when no beat is taken
    if (!accept) begin
      cmd.kind = ple_pkg::CMD_NONE;
    end
    res.length = count_next;
  end

  // Advance the length on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: controller plus a row of cells.
// Depends on ple_pkg, ple_ctrl and ple_cell.
//
// Usage:
//   Drive op, pos and value and raise start; a beat is taken at each rising
//   edge with start high and busy low. busy never rises in this design, so
//   a new beat can be taken in every cycle.
//   Each beat gives exactly one result in the next cycle: done is high for
//   that single cycle with data, status and length. The receiver cannot
//   hold results off; they must be captured when done is high.
//   Throughput: 1 beat per cycle. Every operation, including inserts and
//   removes that move many entries, gives its result in the next cycle
//   because each cell takes its neighbor's entry in parallel.
//   data is the value read or removed, zero otherwise.
//   Reset (rst, synchronous) empties the list and drops done. Entry
//   storage is not cleared; positions at or beyond the length are never
//   read.
module positional_list_engine_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ple_pkg::OP_W-1:0]     op,
  input  logic [ple_pkg::POS_W-1:0]    pos,
  input  logic signed [ple_pkg::VAL_W-1:0] value,
  output logic                         done,
  output logic signed [ple_pkg::VAL_W-1:0] data,
  output logic [ple_pkg::ST_W-1:0]     status,
  output logic [ple_pkg::CNT_W-1:0]    length
);

  logic                       accept;
  ple_pkg::cell_cmd_t         cmd;
  ple_pkg::result_t           res;
  logic [ple_pkg::VAL_W-1:0]  q [ple_pkg::CAPACITY];
  logic [ple_pkg::VAL_W-1:0]  picked;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ple_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .op     (op),
    .pos    (pos),
    .value  (value),
    .cmd    (cmd),
    .res    (res)
  );

  // Row of cells; the ends take their own value as the missing neighbor
  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    logic [ple_pkg::VAL_W-1:0] left;
    logic [ple_pkg::VAL_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = q[i];
    end else begin : g_mid_l
      assign left = q[i-1];
    end
    if (i == ple_pkg::CAPACITY - 1) begin : g_last
      assign right = q[i];
    end else begin : g_mid_r
      assign right = q[i+1];
    end
    ple_cell u_cell (
      .clk   (clk),
      .slot  (ple_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .q     (q[i])
    );
  end

  // Select the addressed entry before the row moves
  assign picked = res.take ? q[cmd.idx] : '0;

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      data   <= picked;
      status <= res.status;
      length <= res.length;
    end
  end

endmodule

// ===== rtl/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_unit.
module ple_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [ple_pkg::OP_W-1:0]     op,
  input  logic                         done,
  input  logic [ple_pkg::VAL_W-1:0]    data,
  input  logic [ple_pkg::ST_W-1:0]     status,
  input  logic [ple_pkg::CNT_W-1:0]    length
);

  // Every taken beat gives a result in the next cycle
  a_beat_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("result missing after accepted beat");

  // No result without a taken beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without accepted beat");

  // Length never exceeds capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (length <= ple_pkg::CNT_W'(ple_pkg::CAPACITY)))
    else $error("length beyond capacity");

  // Failed operations return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ple_pkg::ST_OK) |-> (data == '0))
    else $error("nonzero data on failed operation");

  // Clear leaves an empty list
  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == ple_pkg::OP_CLEAR) |=> (length == '0))
    else $error("clear did not empty the list");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .op     (op),
  .done   (done),
  .data   (data),
  .status (status),
  .length (length)
);
